// ===== design/stsi_pkg.sv =====
package stsi_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int VALUE_W    = 32;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]          addr_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  localparam count_t CAPACITY_CNT = COUNT_BITS'(CAPACITY);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } command_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new transaction
    logic rd_en;      // read the entry below the pointer (insert) or at it (search)
    logic wr_rd;      // move the entry just read up to the pointer slot
    logic wr_key;     // place the key at the pointer slot, bump the count
    logic ptr_dec;
    logic ptr_inc;
    logic set_found;
    logic set_reject;
    logic push;       // load the output register
  } stsi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_search;
    logic full;
    logic ptr_zero;
    logic ptr_end;
    logic cmp_gt;
    logic cmp_eq;
    logic out_free;
  } stsi_status_t;

endpackage

// ===== design/stsi_req_if.sv =====
interface stsi_req_if import stsi_pkg::*;;
  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== design/stsi_rsp_if.sv =====
interface stsi_rsp_if import stsi_pkg::*;;
  logic         valid;
  logic         ready;
  logic         found;
  logic         rejected;
  logic [6:0]   entry_count;

  modport source (output valid, output found, output rejected, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input rejected, input entry_count,
                  output ready);
endinterface

// ===== design/sorted_table_insert_search.sv =====
// Channel  Dir  Payload                          Transaction when
// req      in   command, value                   req.valid && req.ready
// rsp      out  found, rejected, entry_count     rsp.valid && rsp.ready
//
// One result per request. Entries sit in a single-port-write, registered-read
// memory; each entry visited is read, then compared.
// Search walks up from slot 0 and stops at an equal or larger entry or at the end.
// Insert walks down from the count, shifting larger entries up; a full table is rejected.
// Synchronous reset clears the count and the output valid flag; no clearing pass.
// A stalled rsp holds its result; the next request is taken meanwhile.
module sorted_table_insert_search import stsi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  stsi_req_if.sink     req,
  stsi_rsp_if.source   rsp
);

  stsi_cmd_t    cmd;
  stsi_status_t status;
  count_t       entry_count;

  stsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  stsi_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_command      (req.command),
    .in_value        (req.value),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_found       (rsp.found),
    .out_rejected    (rsp.rejected),
    .out_entry_count (entry_count)
  );

  assign rsp.entry_count = 7'(entry_count);

endmodule

// ===== design/stsi_ctrl.sv =====
module stsi_ctrl import stsi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  stsi_status_t status,
  output stsi_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.is_search) begin
          priority if (status.full) begin
            cmd.set_reject = 1'b1;
            state_next     = S_DONE;
          end else if (status.ptr_zero) begin
            cmd.wr_key = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_CMP;
          end
        end else begin
          if (status.ptr_end) begin
            state_next = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (!status.is_search) begin
          // walk down: shift larger entries up, stop at the first one not larger
          if (status.cmp_gt) begin
            cmd.wr_rd   = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_next  = S_CHECK;
          end else begin
            cmd.wr_key = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          priority if (status.cmp_eq) begin
            cmd.set_found = 1'b1;
            state_next    = S_DONE;
          end else if (status.cmp_gt) begin
            state_next = S_DONE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_goes_check: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK)
    else $error("transaction load not followed by check");

  a_push_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> status.out_free)
    else $error("push into a busy output register");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_rd && cmd.wr_key))
    else $error("two writes in one cycle");

endmodule

// ===== design/stsi_dpath.sv =====
module stsi_dpath import stsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  stsi_cmd_t          cmd,
  output stsi_status_t       status,
  input  logic               in_command,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic               out_rejected,
  output count_t             out_entry_count
);

  value_t   entries [CAPACITY];
  value_t   key;
  value_t   rd_data;
  command_t op;
  count_t   count;
  count_t   ptr;
  count_t   rd_ptr;
  logic     found;
  logic     rejected;
  addr_t    rd_addr;
  addr_t    wr_addr;
  value_t   wr_data;
  logic     wr_en;

  // insert looks one slot below the pointer, search looks at the pointer
  assign rd_ptr  = (op == CMD_INSERT) ? (ptr - count_t'(1)) : ptr;
  assign rd_addr = rd_ptr[IDX_BITS-1:0];
  assign wr_addr = ptr[IDX_BITS-1:0];
  assign wr_en   = cmd.wr_rd | cmd.wr_key;
  assign wr_data = cmd.wr_key ? key : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= entries[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= command_t'(in_command);
      key <= in_value[VALUE_BITS-1:0];
    end
    if (cmd.load) begin
      found    <= 1'b0;
      rejected <= 1'b0;
    end else begin
      if (cmd.set_found) begin
        found <= 1'b1;
      end
      if (cmd.set_reject) begin
        rejected <= 1'b1;
      end
    end
    if (cmd.load) begin
      ptr <= (command_t'(in_command) == CMD_INSERT) ? count : '0;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - count_t'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + count_t'(1);
    end
    if (cmd.push) begin
      out_found       <= found;
      out_rejected    <= rejected;
      out_entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_key) begin
        count <= count + count_t'(1);
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.is_search = (op == CMD_SEARCH);
    status.full      = (count == CAPACITY_CNT);
    status.ptr_zero  = (ptr == '0);
    status.ptr_end   = (ptr == count);
    status.cmp_gt    = (rd_data > key);
    status.cmp_eq    = (rd_data == key);
    status.out_free  = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAPACITY_CNT)
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.wr_key |=> $stable(count))
    else $error("entry count moved without an insert");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    cmd.set_reject |-> status.full && !status.is_search)
    else $error("insert rejected while table not full");

endmodule

// ===== dv/sorted_table_checker.sv =====
`timescale 1ns / 100ps

module sorted_table_checker import stsi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic run_done,
  stsi_req_if  req,
  stsi_rsp_if  rsp,
  output int   replies_pending,
  output int   mismatch_count
);

  localparam int REPORT_LINES = 30;

  typedef struct packed {
    logic       found;
    logic       rejected;
    logic [6:0] entry_count;
  } table_reply_t;

  value_t       held_values [CAPACITY];
  int           held_count;
  table_reply_t expected_replies [$];
  int           replies_seen;
  bit           leftovers_reported;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // Update the table copy and work out the reply for one request.
  function automatic table_reply_t apply_request(command_t cmd, value_t key);
    table_reply_t reply;
    int           slot;
    int           i;
    reply = '0;
    if (cmd == CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        reply.rejected = 1'b1;
      end else begin
        slot = 0;
        // skip equal keys too: the new one goes after them
        while (slot < held_count && held_values[slot] <= key) slot++;
        for (i = held_count; i > slot; i--) held_values[i] = held_values[i-1];
        held_values[slot] = key;
        held_count++;
      end
    end else begin
      for (i = 0; i < held_count; i++) begin
        if (held_values[i] == key) reply.found = 1'b1;
      end
    end
    reply.entry_count = 7'(held_count);
    return reply;
  endfunction

  always @(posedge clk) begin : monitor
    table_reply_t want;
    table_reply_t got;
    if (rst) begin
      held_count         = 0;
      replies_seen       = 0;
      mismatch_count     = 0;
      leftovers_reported = 1'b0;
      expected_replies.delete();
      replies_pending   <= 0;
    end else begin
      // check the reply before queueing this edge's request
      if (rsp.valid && rsp.ready) begin
        got.found       = rsp.found;
        got.rejected    = rsp.rejected;
        got.entry_count = rsp.entry_count;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply %0d arrived with none outstanding", replies_seen));
        end else begin
          want = expected_replies.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("reply %0d: found %b, want %b",
                                      replies_seen, got.found, want.found));
          if (got.rejected !== want.rejected)
            report_mismatch($sformatf("reply %0d: rejected %b, want %b",
                                      replies_seen, got.rejected, want.rejected));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("reply %0d: entry_count %0d, want %0d",
                                      replies_seen, got.entry_count, want.entry_count));
        end
        replies_seen++;
      end
      if (req.valid && req.ready) begin
        expected_replies.push_back(apply_request(command_t'(req.command), value_t'(req.value)));
      end
      if (run_done && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        while (expected_replies.size() != 0) begin
          want = expected_replies.pop_front();
          report_mismatch($sformatf("reply never arrived: found %b rejected %b count %0d",
                                    want.found, want.rejected, want.entry_count));
        end
      end
      replies_pending <= expected_replies.size();
    end
  end

endmodule

// ===== dv/sorted_table_insert_search_test.sv =====
`timescale 1ns / 100ps

module sorted_table_insert_search_test;
  import stsi_pkg::*;

  localparam int RANDOM_ITEMS   = 1030;
  localparam int HOLD_OFF_START = 500;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int IDLE_LIMIT     = 3000;

  localparam value_t VALUE_MAX = value_t'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam value_t VALUE_MIN = value_t'({1'b1, {(VALUE_BITS-1){1'b0}}});

  logic clk;
  logic rst;
  logic run_done;
  int   replies_pending;
  int   mismatch_count;

  int     items_sent;
  int     burst_left;
  bit     hold_off_done;
  value_t offered_values [$];

  stsi_req_if req_if ();
  stsi_rsp_if rsp_if ();

  sorted_table_insert_search DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  sorted_table_checker table_check (
    .clk             (clk),
    .rst             (rst),
    .run_done        (run_done),
    .req             (req_if),
    .rsp             (rsp_if),
    .replies_pending (replies_pending),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one request, hold it until taken, then maybe pause between bursts.
  task automatic send_request(input command_t cmd, input value_t v);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.value   <= v;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    if (cmd == CMD_INSERT) offered_values.push_back(v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // Favor values already inserted and their neighbors so searches hit.
  function automatic value_t pick_value();
    int     sel;
    value_t base;
    sel = $urandom_range(0, 99);
    if (offered_values.size() != 0)
      base = offered_values[$urandom_range(0, offered_values.size() - 1)];
    else
      base = value_t'($urandom);
    if (sel < 35) return base;
    if (sel < 50) return ($urandom_range(0, 1) != 0) ? base + value_t'(1) : base - value_t'(1);
    if (sel < 60) return value_t'(int'($urandom_range(0, 16)) - 8);
    if (sel < 68) begin
      case ($urandom_range(0, 5))
        0:       return VALUE_MIN;
        1:       return VALUE_MIN + value_t'(1);
        2:       return VALUE_MAX;
        3:       return VALUE_MAX - value_t'(1);
        4:       return value_t'(0);
        default: return value_t'(-1);
      endcase
    end
    return value_t'($urandom);
  endfunction

  initial begin : stimulus
    command_t cmd;
    int       n;
    rst            <= 1'b1;
    run_done       <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_INSERT;
    req_if.value   <= '0;
    items_sent      = 0;
    burst_left      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicates, hits and misses
    send_request(CMD_SEARCH, value_t'(0));
    send_request(CMD_SEARCH, VALUE_MIN);
    send_request(CMD_INSERT, value_t'(5));
    send_request(CMD_INSERT, value_t'(5));
    send_request(CMD_INSERT, value_t'(-3));
    send_request(CMD_INSERT, VALUE_MAX);
    send_request(CMD_INSERT, VALUE_MIN);
    send_request(CMD_INSERT, value_t'(0));
    send_request(CMD_INSERT, value_t'(-1));
    send_request(CMD_INSERT, value_t'(4));
    send_request(CMD_INSERT, value_t'(6));
    send_request(CMD_INSERT, value_t'(5));
    send_request(CMD_SEARCH, value_t'(5));
    send_request(CMD_SEARCH, value_t'(4));
    send_request(CMD_SEARCH, VALUE_MAX);
    send_request(CMD_SEARCH, VALUE_MIN);
    send_request(CMD_SEARCH, value_t'(7));
    send_request(CMD_SEARCH, value_t'(-2));
    send_request(CMD_SEARCH, value_t'(32'haaaa_aaaa));
    send_request(CMD_INSERT, value_t'(32'h5555_5555));
    send_request(CMD_SEARCH, value_t'(32'h5555_5555));
    send_request(CMD_SEARCH, VALUE_MAX - value_t'(1));

    // inserts are sparse, yet the table fills well before the end of the run
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = ($urandom_range(0, 99) < 14) ? CMD_INSERT : CMD_SEARCH;
      send_request(cmd, pick_value());
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : reply_sink
    int         phase_left;
    int         mode;
    logic [7:0] pattern;
    rsp_if.ready <= 1'b0;
    phase_left    = 0;
    mode          = 0;
    pattern       = 8'b1011_0110;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      // hold off long enough for the block to back up and stall requests
      if (!hold_off_done && items_sent >= HOLD_OFF_START) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(50, 300);
      end
      phase_left--;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: begin
          rsp_if.ready <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
        2:       rsp_if.ready <= ($urandom_range(0, 1) != 0);
        default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sorted_table_insert_search.f =====
design/stsi_pkg.sv
design/stsi_req_if.sv
design/stsi_rsp_if.sv
design/stsi_ctrl.sv
design/stsi_dpath.sv
design/sorted_table_insert_search.sv
dv/sorted_table_checker.sv
dv/sorted_table_insert_search_test.sv
